[hdl/config_record_checker_top_assert.svh]
// assertion macros for the checker files
`ifndef CONFIG_RECORD_CHECKER_TOP_ASSERT_SVH
`define CONFIG_RECORD_CHECKER_TOP_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CRC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/cfgrec_pkg.sv]
`default_nettype none

package cfgrec_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam logic [31:0] PENALTY_MAX = 32'd3600000;
  localparam logic [6:0]  SECRET_MIN  = 7'd8;
  localparam int          NAME_OFF    = 19;

  // "LPC1", offset 0 in the low byte
  localparam logic [3:0][7:0] MAGIC = {8'h31, 8'h43, 8'h50, 8'h4C};

  typedef enum logic [2:0] {
    FAIL_NONE    = 3'd0,
    FAIL_LENGTH  = 3'd1,
    FAIL_MAGIC   = 3'd2,
    FAIL_VERSION = 3'd3,
    FAIL_CRC     = 3'd4,
    FAIL_CONTENT = 3'd5
  } fail_reason_t;

  typedef struct packed {
    logic         record_ok;
    fail_reason_t fail_reason;
    logic [31:0]  penalty_time;
    logic [31:0]  run_limit_time;
    logic [15:0]  country_code;
    logic [5:0]   name_length;
    logic [6:0]   secret_length;
  } rec_result_t;

  // reflected crc-32, one byte unrolled
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hdl/cfgrec_scan.sv]
`default_nettype none

module cfgrec_scan #(
  parameter int RECORD_BYTES       = 120,
  parameter int NAME_FIELD_BYTES   = 32,
  parameter int SECRET_FIELD_BYTES = 63
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   last_byte,
  input  wire logic [7:0]             format_version,
  output cfgrec_pkg::rec_result_t     result
);

  localparam int PW         = $clog2(RECORD_BYTES + 1);
  localparam int CRC_OFF    = RECORD_BYTES - 4;
  localparam int SECRET_OFF = cfgrec_pkg::NAME_OFF + NAME_FIELD_BYTES + 1;
  localparam int SECRET_END = SECRET_OFF + SECRET_FIELD_BYTES;

  localparam logic [PW-1:0] P_END        = PW'(RECORD_BYTES);
  localparam logic [PW-1:0] P_LAST       = PW'(RECORD_BYTES - 1);
  localparam logic [PW-1:0] P_CRC_OFF    = PW'(CRC_OFF);
  localparam logic [PW-1:0] P_CRC_HOLD   = PW'(CRC_OFF - 1);
  localparam logic [PW-1:0] P_MAGIC_END  = PW'(4);
  localparam logic [PW-1:0] P_VERSION    = PW'(4);
  localparam logic [PW-1:0] P_PENALTY    = PW'(8);
  localparam logic [PW-1:0] P_RUN        = PW'(12);
  localparam logic [PW-1:0] P_COUNTRY    = PW'(16);
  localparam logic [PW-1:0] P_COUNTRY_HI = PW'(17);
  localparam logic [PW-1:0] P_COUNTRY_Z  = PW'(18);
  localparam logic [PW-1:0] P_NAME       = PW'(cfgrec_pkg::NAME_OFF);
  localparam logic [PW-1:0] P_SECRET     = PW'(SECRET_OFF);
  localparam logic [PW-1:0] P_SECRET_END = PW'(SECRET_END);
  localparam logic [5:0]    NAME_LIMIT   = 6'(NAME_FIELD_BYTES);
  localparam logic [6:0]    SECRET_LIMIT = 7'(SECRET_FIELD_BYTES);

  logic [PW-1:0] pos_r, pos_upd, pos_nxt;
  logic          overrun_r, overrun_upd, overrun_nxt;
  logic [31:0]   run_crc_r, run_crc_upd, run_crc_nxt;
  logic [31:0]   held_crc_r, held_crc_upd, held_crc_nxt;
  logic [31:0]   rcv_crc_r, rcv_crc_upd, rcv_crc_nxt;
  logic          magic_good_r, magic_good_upd, magic_good_nxt;
  logic          version_good_r, version_good_upd, version_good_nxt;
  logic [31:0]   penalty_r, penalty_upd, penalty_nxt;
  logic [31:0]   run_limit_r, run_limit_upd, run_limit_nxt;
  logic [15:0]   country_r, country_upd, country_nxt;
  logic          country_z_r, country_z_upd, country_z_nxt;
  logic [5:0]    name_cnt_r, name_cnt_upd, name_cnt_nxt;
  logic          name_end_r, name_end_upd, name_end_nxt;
  logic [6:0]    secret_cnt_r, secret_cnt_upd, secret_cnt_nxt;
  logic          secret_end_r, secret_end_upd, secret_end_nxt;
  logic          term_good_r, term_good_upd, term_good_nxt;

  logic [31:0] crc_step;
  logic        length_ok;
  logic        crc_match;
  logic        content_ok;
  logic        finish;

  assign crc_step = cfgrec_pkg::crc32_byte(run_crc_r, data_byte);

  // byte update of the record state
  always_comb begin
    pos_upd          = pos_r;
    overrun_upd      = overrun_r;
    run_crc_upd      = run_crc_r;
    held_crc_upd     = held_crc_r;
    rcv_crc_upd      = rcv_crc_r;
    magic_good_upd   = magic_good_r;
    version_good_upd = version_good_r;
    penalty_upd      = penalty_r;
    run_limit_upd    = run_limit_r;
    country_upd      = country_r;
    country_z_upd    = country_z_r;
    name_cnt_upd     = name_cnt_r;
    name_end_upd     = name_end_r;
    secret_cnt_upd   = secret_cnt_r;
    secret_end_upd   = secret_end_r;
    term_good_upd    = term_good_r;

    if (pos_r == P_END) begin
      overrun_upd = 1'b1;
    end else begin
      pos_upd = pos_r + PW'(1);
      if (pos_r < P_CRC_OFF) begin
        run_crc_upd = crc_step;
        if (pos_r == P_CRC_HOLD) begin
          held_crc_upd = ~crc_step;
        end
      end else begin
        rcv_crc_upd = {data_byte, rcv_crc_r[31:8]};
      end
      if (pos_r < P_MAGIC_END && data_byte != cfgrec_pkg::MAGIC[pos_r[1:0]]) begin
        magic_good_upd = 1'b0;
      end
      if (pos_r == P_VERSION && data_byte != format_version) begin
        version_good_upd = 1'b0;
      end
      if (pos_r >= P_PENALTY && pos_r < P_RUN) begin
        penalty_upd = {data_byte, penalty_r[31:8]};
      end
      if (pos_r >= P_RUN && pos_r < P_COUNTRY) begin
        run_limit_upd = {data_byte, run_limit_r[31:8]};
      end
      if (pos_r == P_COUNTRY) begin
        country_upd = {country_r[15:8], data_byte};
      end
      if (pos_r == P_COUNTRY_HI) begin
        country_upd = {data_byte, country_r[7:0]};
      end
      if (pos_r == P_COUNTRY_Z) begin
        country_z_upd = (data_byte == 8'd0);
      end
      if (pos_r >= P_NAME && pos_r < P_SECRET) begin
        if (!name_end_r) begin
          if (data_byte == 8'd0) name_end_upd = 1'b1;
          else name_cnt_upd = name_cnt_r + 6'd1;
        end
        // name field must end in a zero
        if (pos_r == P_SECRET - PW'(1) && data_byte != 8'd0) begin
          term_good_upd = 1'b0;
        end
      end
      if (pos_r >= P_SECRET && pos_r <= P_SECRET_END) begin
        if (!secret_end_r) begin
          if (data_byte == 8'd0) secret_end_upd = 1'b1;
          else secret_cnt_upd = secret_cnt_r + 7'd1;
        end
        if (pos_r == P_SECRET_END && data_byte != 8'd0) begin
          term_good_upd = 1'b0;
        end
      end
    end
  end

  // a full-length record ends on a crc byte, so all other checks are settled already
  assign length_ok = !overrun_r && (pos_r == P_LAST);
  assign crc_match = (held_crc_r == {data_byte, rcv_crc_r[31:8]});
  assign content_ok = (penalty_r <= cfgrec_pkg::PENALTY_MAX) && (run_limit_r != 32'd0) &&
                      (country_r[7:0] != 8'd0) && (country_r[15:8] != 8'd0) &&
                      country_z_r && term_good_r &&
                      (name_cnt_r != 6'd0) && (name_cnt_r <= NAME_LIMIT) &&
                      (secret_cnt_r >= cfgrec_pkg::SECRET_MIN) &&
                      (secret_cnt_r <= SECRET_LIMIT);

  always_comb begin
    if (!length_ok)         result.fail_reason = cfgrec_pkg::FAIL_LENGTH;
    else if (!magic_good_r)   result.fail_reason = cfgrec_pkg::FAIL_MAGIC;
    else if (!version_good_r) result.fail_reason = cfgrec_pkg::FAIL_VERSION;
    else if (!crc_match)      result.fail_reason = cfgrec_pkg::FAIL_CRC;
    else if (!content_ok)     result.fail_reason = cfgrec_pkg::FAIL_CONTENT;
    else                      result.fail_reason = cfgrec_pkg::FAIL_NONE;
    result.record_ok      = (result.fail_reason == cfgrec_pkg::FAIL_NONE);
    result.penalty_time   = penalty_upd;
    result.run_limit_time = run_limit_upd;
    result.country_code   = country_upd;
    result.name_length    = name_cnt_upd;
    result.secret_length  = secret_cnt_upd;
  end

  assign finish = step && last_byte;

  // state returns to its cleared value after the final byte
  always_comb begin
    if (finish) begin
      pos_nxt          = '0;
      overrun_nxt      = 1'b0;
      run_crc_nxt      = cfgrec_pkg::CRC_INIT;
      held_crc_nxt     = '0;
      rcv_crc_nxt      = '0;
      magic_good_nxt   = 1'b1;
      version_good_nxt = 1'b1;
      penalty_nxt      = '0;
      run_limit_nxt    = '0;
      country_nxt      = '0;
      country_z_nxt    = 1'b0;
      name_cnt_nxt     = '0;
      name_end_nxt     = 1'b0;
      secret_cnt_nxt   = '0;
      secret_end_nxt   = 1'b0;
      term_good_nxt    = 1'b1;
    end else if (step) begin
      pos_nxt          = pos_upd;
      overrun_nxt      = overrun_upd;
      run_crc_nxt      = run_crc_upd;
      held_crc_nxt     = held_crc_upd;
      rcv_crc_nxt      = rcv_crc_upd;
      magic_good_nxt   = magic_good_upd;
      version_good_nxt = version_good_upd;
      penalty_nxt      = penalty_upd;
      run_limit_nxt    = run_limit_upd;
      country_nxt      = country_upd;
      country_z_nxt    = country_z_upd;
      name_cnt_nxt     = name_cnt_upd;
      name_end_nxt     = name_end_upd;
      secret_cnt_nxt   = secret_cnt_upd;
      secret_end_nxt   = secret_end_upd;
      term_good_nxt    = term_good_upd;
    end else begin
      pos_nxt          = pos_r;
      overrun_nxt      = overrun_r;
      run_crc_nxt      = run_crc_r;
      held_crc_nxt     = held_crc_r;
      rcv_crc_nxt      = rcv_crc_r;
      magic_good_nxt   = magic_good_r;
      version_good_nxt = version_good_r;
      penalty_nxt      = penalty_r;
      run_limit_nxt    = run_limit_r;
      country_nxt      = country_r;
      country_z_nxt    = country_z_r;
      name_cnt_nxt     = name_cnt_r;
      name_end_nxt     = name_end_r;
      secret_cnt_nxt   = secret_cnt_r;
      secret_end_nxt   = secret_end_r;
      term_good_nxt    = term_good_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      overrun_r      <= 1'b0;
      run_crc_r      <= cfgrec_pkg::CRC_INIT;
      held_crc_r     <= '0;
      rcv_crc_r      <= '0;
      magic_good_r   <= 1'b1;
      version_good_r <= 1'b1;
      penalty_r      <= '0;
      run_limit_r    <= '0;
      country_r      <= '0;
      country_z_r    <= 1'b0;
      name_cnt_r     <= '0;
      name_end_r     <= 1'b0;
      secret_cnt_r   <= '0;
      secret_end_r   <= 1'b0;
      term_good_r    <= 1'b1;
    end else begin
      pos_r          <= pos_nxt;
      overrun_r      <= overrun_nxt;
      run_crc_r      <= run_crc_nxt;
      held_crc_r     <= held_crc_nxt;
      rcv_crc_r      <= rcv_crc_nxt;
      magic_good_r   <= magic_good_nxt;
      version_good_r <= version_good_nxt;
      penalty_r      <= penalty_nxt;
      run_limit_r    <= run_limit_nxt;
      country_r      <= country_nxt;
      country_z_r    <= country_z_nxt;
      name_cnt_r     <= name_cnt_nxt;
      name_end_r     <= name_end_nxt;
      secret_cnt_r   <= secret_cnt_nxt;
      secret_end_r   <= secret_end_nxt;
      term_good_r    <= term_good_nxt;
    end
  end

endmodule

`default_nettype wire

[hdl/config_record_checker_top.sv]
// Settings record checker. Takes one record byte per cycle on the in_ channel and gives one
// result transfer on the out_ channel for the byte marked last: pass/fail, the first failing
// check (length, magic "LPC1", version, crc-32, content) and the decoded times, country code
// and name/password lengths. Throughput is one byte per cycle, set by the one-byte unrolled
// crc step between the input register and the record state, while no last byte waits on a
// stalled result. Once its last byte is taken, a result reaches out_ via the input register,
// then the result register; the next record may follow directly. cfg_format_version sets the
// expected version byte and should be written only while no record is in flight.
`default_nettype none

module config_record_checker_top #(
  parameter int RECORD_BYTES       = 120,
  parameter int NAME_FIELD_BYTES   = 32,
  parameter int SECRET_FIELD_BYTES = 63
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output wire logic        cfg_ready,
  input  wire logic [7:0]  cfg_format_version,
  input  wire logic        in_valid,
  output wire logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output wire logic        out_valid,
  input  wire logic        out_ready,
  output wire logic        out_record_ok,
  output wire logic [2:0]  out_fail_reason,
  output wire logic [31:0] out_penalty_time,
  output wire logic [31:0] out_run_limit_time,
  output wire logic [15:0] out_country_code,
  output wire logic [5:0]  out_name_length,
  output wire logic [6:0]  out_secret_length
);

  logic [7:0]  format_version_r, format_version_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r, s1_byte_nxt;
  logic        s1_last_r, s1_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  cfgrec_pkg::rec_result_t out_r, out_nxt;
  cfgrec_pkg::rec_result_t result;
  logic        s1_fire;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  // a byte with no result always moves on; a last byte needs room in the result register
  assign s1_fire  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  cfgrec_scan #(
    .RECORD_BYTES      (RECORD_BYTES),
    .NAME_FIELD_BYTES  (NAME_FIELD_BYTES),
    .SECRET_FIELD_BYTES(SECRET_FIELD_BYTES)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_fire),
    .data_byte     (s1_byte_r),
    .last_byte     (s1_last_r),
    .format_version(format_version_r),
    .result        (result)
  );

  always_comb begin
    format_version_nxt = (cfg_valid && cfg_ready) ? cfg_format_version : format_version_r;
    s1_byte_nxt  = in_fire ? in_data_byte : s1_byte_r;
    s1_last_nxt  = in_fire ? in_last_byte : s1_last_r;
    s1_valid_nxt = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (s1_fire && s1_last_r) begin
      out_nxt       = result;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_version_r <= 8'd1;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      format_version_r <= format_version_nxt;
      s1_valid_r       <= s1_valid_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    s1_last_r <= s1_last_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_record_ok      = out_r.record_ok;
  assign out_fail_reason    = out_r.fail_reason;
  assign out_penalty_time   = out_r.penalty_time;
  assign out_run_limit_time = out_r.run_limit_time;
  assign out_country_code   = out_r.country_code;
  assign out_name_length    = out_r.name_length;
  assign out_secret_length  = out_r.secret_length;

endmodule

`default_nettype wire

[hdl/cfgrec_port_checker.sv]
`default_nettype none
`include "config_record_checker_top_assert.svh"

module cfgrec_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_record_ok,
  input wire logic [2:0]  out_fail_reason,
  input wire logic [31:0] out_penalty_time,
  input wire logic [31:0] out_run_limit_time,
  input wire logic [15:0] out_country_code,
  input wire logic [5:0]  out_name_length,
  input wire logic [6:0]  out_secret_length
);

  logic        stalled;
  logic        pass_shown;
  logic [96:0] out_word;
  logic        ok_agrees;
  logic        reason_legal;
  logic        content_legal;

  assign stalled    = out_valid && !out_ready;
  assign pass_shown = out_valid && out_record_ok;
  assign out_word   = {out_record_ok, out_fail_reason, out_penalty_time, out_run_limit_time,
                       out_country_code, out_name_length, out_secret_length};
  assign ok_agrees    = (out_record_ok == (out_fail_reason == cfgrec_pkg::FAIL_NONE));
  assign reason_legal = (out_fail_reason <= cfgrec_pkg::FAIL_CONTENT);
  assign content_legal = (out_penalty_time <= cfgrec_pkg::PENALTY_MAX) &&
                         (out_run_limit_time != 32'd0) && (out_name_length != 6'd0) &&
                         (out_secret_length >= cfgrec_pkg::SECRET_MIN) &&
                         (out_country_code[7:0] != 8'd0) && (out_country_code[15:8] != 8'd0);

  // a stalled result holds its verdict and decoded fields
  `CRC_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "stalled result changed")

  `CRC_ASSERT_ALWAYS(a_ok_reason, !out_valid || ok_agrees, "ok flag disagrees with reason")

  `CRC_ASSERT_ALWAYS(a_reason_range, !out_valid || reason_legal, "reason code out of range")

  // a passing record obeys the content limits
  `CRC_ASSERT_ALWAYS(a_pass_content, !pass_shown || content_legal, "pass breaks content limits")

endmodule

bind config_record_checker_top cfgrec_port_checker u_port_checker (.*);

`default_nettype wire

[tb/record_verdict_checker.sv]
module record_verdict_checker #(
  parameter int REC_LEN      = 120,
  parameter int NAME_FIELD   = 32,
  parameter int SECRET_FIELD = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_format_version,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_record_ok,
  input  logic [2:0]  out_fail_reason,
  input  logic [31:0] out_penalty_time,
  input  logic [31:0] out_run_limit_time,
  input  logic [15:0] out_country_code,
  input  logic [5:0]  out_name_length,
  input  logic [6:0]  out_secret_length,
  output int          mismatch_count,
  output int          awaiting_count,
  output int          verdicts_seen,
  output int          verdicts_passed
);
  timeunit 1ns;
  timeprecision 1ps;

  import cfgrec_pkg::*;

  localparam int SECRET_AT = NAME_OFF + NAME_FIELD + 1;
  localparam int SECRET_END = SECRET_AT + SECRET_FIELD + 1;
  localparam int CRC_AT = REC_LEN - 4;

  logic [31:0] crc_table [256];
  rec_result_t verdicts [$];
  logic [7:0]  version_expect;

  // running picture of the record being received
  int          rec_pos;
  bit          overrun;
  logic [31:0] crc_acc;
  logic [31:0] crc_sealed;
  logic [31:0] crc_rx;
  bit          magic_ok;
  bit          version_ok;
  logic [31:0] penalty_acc;
  logic [31:0] run_acc;
  logic [15:0] country_acc;
  bit          country_closed;
  int          name_cnt;
  bit          name_done;
  int          secret_cnt;
  bit          secret_done;
  bit          tails_ok;

  // table-driven crc so the check does not share the block's bitwise form
  initial begin
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_table[i] = c;
    end
  end

  task automatic clear_tally();
    rec_pos        = 0;
    overrun        = 1'b0;
    crc_acc        = CRC_INIT;
    crc_sealed     = '0;
    crc_rx         = '0;
    magic_ok       = 1'b1;
    version_ok     = 1'b1;
    penalty_acc    = '0;
    run_acc        = '0;
    country_acc    = '0;
    country_closed = 1'b0;
    name_cnt       = 0;
    name_done      = 1'b0;
    secret_cnt     = 0;
    secret_done    = 1'b0;
    tails_ok       = 1'b1;
  endtask

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    $error("%s mismatch: expected %0h, got %0h", field, want_v, got_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rec_result_t  want;
    logic [7:0]   b;
    int           p;
    bit           fields_ok;
    fail_reason_t why;
    if (!rst_n) begin
      clear_tally();
      version_expect = 8'd1;
      verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts.size() == 0) begin
          $error("result transfer while no record has ended");
          mismatch_count++;
        end else begin
          want = verdicts.pop_front();
          if (out_record_ok !== want.record_ok)
            report_field("record_ok", want.record_ok, out_record_ok);
          if (out_fail_reason !== want.fail_reason)
            report_field("fail_reason", want.fail_reason, out_fail_reason);
          if (out_penalty_time !== want.penalty_time)
            report_field("penalty_time", want.penalty_time, out_penalty_time);
          if (out_run_limit_time !== want.run_limit_time)
            report_field("run_limit_time", want.run_limit_time, out_run_limit_time);
          if (out_country_code !== want.country_code)
            report_field("country_code", want.country_code, out_country_code);
          if (out_name_length !== want.name_length)
            report_field("name_length", want.name_length, out_name_length);
          if (out_secret_length !== want.secret_length)
            report_field("secret_length", want.secret_length, out_secret_length);
          verdicts_seen++;
          if (want.record_ok) verdicts_passed++;
        end
      end

      if (cfg_valid && cfg_ready) version_expect = cfg_format_version;

      if (in_valid && in_ready) begin
        b = in_data_byte;
        p = rec_pos;
        if (p >= REC_LEN) begin
          // bytes past the record end only mark the overrun
          overrun = 1'b1;
        end else begin
          if (p < CRC_AT) begin
            crc_acc = (crc_acc >> 8) ^ crc_table[crc_acc[7:0] ^ b];
            if (p == CRC_AT - 1) crc_sealed = ~crc_acc;
          end else begin
            crc_rx = {b, crc_rx[31:8]};
          end
          if (p < 4 && b != MAGIC[p]) magic_ok = 1'b0;
          if (p == 4 && b != version_expect) version_ok = 1'b0;
          if (p >= 8 && p < 12) penalty_acc = {b, penalty_acc[31:8]};
          if (p >= 12 && p < 16) run_acc = {b, run_acc[31:8]};
          if (p == 16) country_acc[7:0] = b;
          if (p == 17) country_acc[15:8] = b;
          if (p == 18) country_closed = (b == 8'h00);
          if (p >= NAME_OFF && p < SECRET_AT) begin
            if (!name_done) begin
              if (b == 8'h00) name_done = 1'b1;
              else name_cnt++;
            end
            if (p == SECRET_AT - 1 && b != 8'h00) tails_ok = 1'b0;
          end
          if (p >= SECRET_AT && p < SECRET_END) begin
            if (!secret_done) begin
              if (b == 8'h00) secret_done = 1'b1;
              else secret_cnt++;
            end
            if (p == SECRET_END - 1 && b != 8'h00) tails_ok = 1'b0;
          end
          rec_pos = p + 1;
        end

        if (in_last_byte) begin
          fields_ok = penalty_acc <= PENALTY_MAX && run_acc != 0 &&
                      country_acc[7:0] != 0 && country_acc[15:8] != 0 &&
                      country_closed && tails_ok &&
                      name_cnt >= 1 && name_cnt <= NAME_FIELD &&
                      secret_cnt >= SECRET_MIN && secret_cnt <= SECRET_FIELD;
          if (overrun || p != REC_LEN - 1) why = FAIL_LENGTH;
          else if (!magic_ok) why = FAIL_MAGIC;
          else if (!version_ok) why = FAIL_VERSION;
          else if (crc_sealed != crc_rx) why = FAIL_CRC;
          else if (!fields_ok) why = FAIL_CONTENT;
          else why = FAIL_NONE;
          want.record_ok      = (why == FAIL_NONE);
          want.fail_reason    = why;
          want.penalty_time   = penalty_acc;
          want.run_limit_time = run_acc;
          want.country_code   = country_acc;
          want.name_length    = 6'(name_cnt);
          want.secret_length  = 7'(secret_cnt);
          verdicts.push_back(want);
          clear_tally();
        end
      end
    end
    awaiting_count = verdicts.size();
  end

endmodule

[tb/tb_config_record_checker_top.sv]
module tb_config_record_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REC_LEN      = 120;
  localparam int NAME_FIELD   = 32;
  localparam int SECRET_FIELD = 63;
  localparam int SECRET_AT    = cfgrec_pkg::NAME_OFF + NAME_FIELD + 1;
  localparam int CRC_AT       = REC_LEN - 4;
  localparam int REC_SPAN     = REC_LEN + 12;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 6;
  localparam int CYCLE_LIMIT  = 250000;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_CRC,
    FLAW_RUN_ZERO,
    FLAW_COUNTRY,
    FLAW_NAME_TAIL,
    FLAW_SECRET_TAIL,
    FLAW_NOISE
  } flaw_t;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_CADENCE,
    RDY_SPARSE
  } ready_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_format_version = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_record_ok;
  logic [2:0]  out_fail_reason;
  logic [31:0] out_penalty_time;
  logic [31:0] out_run_limit_time;
  logic [15:0] out_country_code;
  logic [5:0]  out_name_length;
  logic [6:0]  out_secret_length;

  int mismatch_count;
  int awaiting_count;
  int verdicts_seen;
  int verdicts_passed;

  logic [7:0]   rec_bytes [REC_SPAN];
  logic [7:0]   cur_version = 8'd1;
  logic [7:0]   mid_version;
  bit           bursty;
  int           burst_left;
  ready_style_t ready_style = RDY_ALWAYS;
  bit           long_hold_pending;
  int           records_sent;
  int           bytes_sent;
  int           cycle_count;

  config_record_checker_top #(
    .RECORD_BYTES      (REC_LEN),
    .NAME_FIELD_BYTES  (NAME_FIELD),
    .SECRET_FIELD_BYTES(SECRET_FIELD)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_format_version(cfg_format_version),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_ok     (out_record_ok),
    .out_fail_reason   (out_fail_reason),
    .out_penalty_time  (out_penalty_time),
    .out_run_limit_time(out_run_limit_time),
    .out_country_code  (out_country_code),
    .out_name_length   (out_name_length),
    .out_secret_length (out_secret_length)
  );

  record_verdict_checker #(
    .REC_LEN     (REC_LEN),
    .NAME_FIELD  (NAME_FIELD),
    .SECRET_FIELD(SECRET_FIELD)
  ) verdict_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("cycle limit reached with %0d results outstanding", awaiting_count);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: its own ready pattern, plus one long hold-off on request
  initial begin
    int hold_left;
    int beat;
    hold_left = 0;
    beat = 0;
    forever begin
      @(posedge clk);
      beat++;
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_style)
          RDY_ALWAYS:  out_ready <= 1'b1;
          RDY_RANDOM:  out_ready <= ($urandom_range(0, 99) < 60);
          RDY_CADENCE: out_ready <= ((beat % 7) >= 3);
          default:     out_ready <= ($urandom_range(0, 99) < 20);
        endcase
      end
    end
  end

  // lets every outstanding result arrive before returning
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting_count != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_version(input logic [7:0] v);
    drain_results();
    cfg_valid          <= 1'b1;
    cfg_format_version <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_version = v;
  endtask

  // builds a record from the given lengths and penalty, applies at most one flaw, and sends len bytes of it
  task automatic post_record(input int name_len, input int secret_len,
                             input logic [31:0] penalty, input flaw_t flaw,
                             input int len);
    logic [31:0] crc;
    logic [31:0] run;
    int          k;
    int          at;
    for (k = 0; k < REC_SPAN; k++) begin
      rec_bytes[k] = 8'($urandom);
    end
    for (k = 0; k < 4; k++) begin
      rec_bytes[k] = cfgrec_pkg::MAGIC[k];
    end
    rec_bytes[4] = cur_version;
    run = $urandom_range(1, 32'hFFFF_FFFF);
    for (k = 0; k < 4; k++) begin
      rec_bytes[8 + k]  = penalty[8*k +: 8];
      rec_bytes[12 + k] = run[8*k +: 8];
    end
    rec_bytes[16] = 8'($urandom_range(1, 255));
    rec_bytes[17] = 8'($urandom_range(1, 255));
    rec_bytes[18] = 8'h00;
    for (k = 0; k <= NAME_FIELD; k++) begin
      if (k < name_len) rec_bytes[cfgrec_pkg::NAME_OFF + k] = 8'($urandom_range(1, 255));
      else if (k == name_len || k == NAME_FIELD) rec_bytes[cfgrec_pkg::NAME_OFF + k] = 8'h00;
    end
    for (k = 0; k <= SECRET_FIELD; k++) begin
      if (k < secret_len) rec_bytes[SECRET_AT + k] = 8'($urandom_range(1, 255));
      else if (k == secret_len || k == SECRET_FIELD) rec_bytes[SECRET_AT + k] = 8'h00;
    end
    case (flaw)
      FLAW_MAGIC: begin
        at = $urandom_range(0, 3);
        rec_bytes[at] = rec_bytes[at] ^ 8'($urandom_range(1, 255));
      end
      FLAW_VERSION: rec_bytes[4] = cur_version ^ 8'($urandom_range(1, 255));
      FLAW_RUN_ZERO: begin
        for (k = 12; k < 16; k++) begin
          rec_bytes[k] = 8'h00;
        end
      end
      FLAW_COUNTRY: begin
        case ($urandom_range(0, 2))
          0:       rec_bytes[16] = 8'h00;
          1:       rec_bytes[17] = 8'h00;
          default: rec_bytes[18] = 8'($urandom_range(1, 255));
        endcase
      end
      FLAW_NAME_TAIL:   rec_bytes[SECRET_AT - 1] = 8'($urandom_range(1, 255));
      FLAW_SECRET_TAIL: rec_bytes[CRC_AT - 1] = 8'($urandom_range(1, 255));
      default: ;
    endcase
    crc = cfgrec_pkg::CRC_INIT;
    for (k = 0; k < CRC_AT; k++) begin
      crc = cfgrec_pkg::crc32_byte(crc, rec_bytes[k]);
    end
    crc = ~crc;
    for (k = 0; k < 4; k++) begin
      rec_bytes[CRC_AT + k] = crc[8*k +: 8];
    end
    if (flaw == FLAW_CRC) begin
      at = CRC_AT + $urandom_range(0, 3);
      rec_bytes[at] = rec_bytes[at] ^ 8'($urandom_range(1, 255));
    end
    if (flaw == FLAW_NOISE) begin
      for (k = 0; k < REC_SPAN; k++) begin
        rec_bytes[k] = 8'($urandom);
      end
    end

    for (k = 0; k < len; k++) begin
      if (bursty && burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if (burst_left > 0) burst_left--;
      in_valid     <= 1'b1;
      in_data_byte <= rec_bytes[k];
      in_last_byte <= (k == len - 1);
      do @(posedge clk); while (!in_ready);
    end
    bytes_sent += len;
    records_sent++;
  endtask

  task automatic random_record();
    int          nl;
    int          sl;
    int          len;
    int          pick;
    logic [31:0] pen;
    flaw_t       flaw;
    if ($urandom_range(0, 9) == 0) nl = $urandom_range(0, 1) ? 0 : NAME_FIELD + 1;
    else nl = $urandom_range(1, NAME_FIELD);
    if ($urandom_range(0, 9) == 0) begin
      sl = $urandom_range(0, 1) ? $urandom_range(0, cfgrec_pkg::SECRET_MIN - 1)
                                : SECRET_FIELD + 1;
    end else begin
      sl = $urandom_range(cfgrec_pkg::SECRET_MIN, SECRET_FIELD);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0) pen = $urandom_range(cfgrec_pkg::PENALTY_MAX + 1, 32'hFFFF_FFFF);
    else if (pick == 1) pen = cfgrec_pkg::PENALTY_MAX;
    else pen = $urandom_range(0, cfgrec_pkg::PENALTY_MAX);
    if ($urandom_range(0, 1)) flaw = FLAW_NONE;
    else flaw = flaw_t'($urandom_range(int'(FLAW_MAGIC), int'(FLAW_NOISE)));
    pick = $urandom_range(0, 99);
    if (pick < 78) len = REC_LEN;
    else if (pick < 84) len = $urandom_range(1, 4);
    else if (pick < 90) len = $urandom_range(5, REC_LEN - 1);
    else len = $urandom_range(REC_LEN + 1, REC_SPAN);
    post_record(nl, sl, pen, flaw, len);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed records under the reset version
    bursty = 1'b0;
    ready_style = RDY_ALWAYS;
    post_record(NAME_FIELD, SECRET_FIELD, cfgrec_pkg::PENALTY_MAX, FLAW_NONE, REC_LEN);
    post_record(4, 9, 32'd7, FLAW_NOISE, 1);
    post_record(4, 9, 32'd7, FLAW_NONE, REC_LEN + 1);
    bursty = 1'b1;
    ready_style = RDY_RANDOM;
    post_record(1, cfgrec_pkg::SECRET_MIN, 32'd0, FLAW_CRC, REC_LEN);
    post_record(4, 9, cfgrec_pkg::PENALTY_MAX + 1, FLAW_NONE, REC_LEN);

    write_version(8'h00);
    ready_style = RDY_CADENCE;
    random_record();

    // long receiver hold while short records are offered back to back
    mid_version = 8'($urandom_range(2, 254));
    write_version(mid_version);
    bursty = 1'b0;
    ready_style = RDY_SPARSE;
    long_hold_pending = 1'b1;
    repeat (40) post_record(4, 9, 32'd7, FLAW_NONE, $urandom_range(1, 3));

    drain_results();
    $display("covered %0d records in %0d byte transfers under versions 1, 0 and %0d",
             records_sent, bytes_sent, mid_version);
    $display("checked %0d results, %0d of them passing records, %0d mismatches",
             verdicts_seen, verdicts_passed, mismatch_count);
    if (mismatch_count == 0 && awaiting_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
